// File: hw/rtl/fbpc_pkg.sv
package fbpc_pkg;

    // Hold counter width default
    localparam int unsigned COUNT_WIDTH_DEF = 8;

    localparam int unsigned NUM_BUTTONS = 4;
    localparam int unsigned CFG_W       = 8;
    localparam int unsigned CFG_ADDR_W  = 3;
    localparam int unsigned EV_W        = 3;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SHORT_TICKS  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_TICKS   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_TICKS = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COUNT_LIMIT  = 3'd3;

    // Register reset values
    localparam logic [CFG_W-1:0] SHORT_TICKS_RST  = 8'd3;
    localparam logic [CFG_W-1:0] LONG_TICKS_RST   = 8'd50;
    localparam logic [CFG_W-1:0] REPEAT_TICKS_RST = 8'd20;
    localparam logic [CFG_W-1:0] COUNT_LIMIT_RST  = 8'd254;

    // Event codes
    localparam logic [EV_W-1:0] EV_WAIT      = 3'd0;
    localparam logic [EV_W-1:0] EV_UP        = 3'd1;
    localparam logic [EV_W-1:0] EV_DOWN      = 3'd2;
    localparam logic [EV_W-1:0] EV_OK        = 3'd3;
    localparam logic [EV_W-1:0] EV_OK_LONG   = 3'd4;
    localparam logic [EV_W-1:0] EV_BACK      = 3'd5;
    localparam logic [EV_W-1:0] EV_BACK_LONG = 3'd6;

    // Lane kinds
    localparam int unsigned KIND_NAV    = 0;
    localparam int unsigned KIND_OK     = 1;
    localparam int unsigned KIND_CANCEL = 2;

    // Button positions
    localparam int unsigned BTN_UP     = 0;
    localparam int unsigned BTN_DOWN   = 1;
    localparam int unsigned BTN_OK     = 2;
    localparam int unsigned BTN_CANCEL = 3;

    typedef struct packed {
        logic [CFG_W-1:0] short_ticks;
        logic [CFG_W-1:0] long_ticks;
        logic [CFG_W-1:0] repeat_ticks;
        logic [CFG_W-1:0] count_limit;
    } cfg_t;

    // What one lane found for this tick
    typedef struct packed {
        logic hit;       // some rule of this lane holds
        logic emit;      // rule emits an event
        logic long_ev;   // event is the long variant
        logic lock_set;
        logic lock_clr;
    } lane_res_t;

    // Merged decision
    typedef struct packed {
        logic                   clear_all;
        logic [EV_W-1:0]        ev;
        logic [NUM_BUTTONS-1:0] lock_set;
        logic [NUM_BUTTONS-1:0] lock_clr;
    } merge_t;

endpackage

// File: hw/rtl/fbpc_lane.sv
module fbpc_lane
    import fbpc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF,
    parameter int unsigned KIND        = KIND_NAV
) (
    input  logic                   pressed,
    input  logic                   lock,
    input  logic [COUNT_WIDTH-1:0] count,
    input  cfg_t                   cfg,
    output logic [COUNT_WIDTH-1:0] count_inc,
    output lane_res_t              res
);

    localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic             enable;
    logic [CMP_W-1:0] cnt_cur;
    logic [CMP_W-1:0] cnt;
    logic [CMP_W-1:0] thr_short;
    logic [CMP_W-1:0] thr_long;
    logic [CMP_W-1:0] thr_rep;
    logic [CMP_W-1:0] thr_lim;
    logic             ge_short;
    logic             ge_long;
    logic             ge_rep;

    // Saturating hold counter; ok and cancel count only while unlocked
    always_comb begin
        enable    = (KIND == KIND_NAV) ? pressed : (pressed && !lock);
        cnt_cur   = CMP_W'(count);
        thr_lim   = CMP_W'(cfg.count_limit);
        if (enable && (cnt_cur <= thr_lim) && (count != CNT_MAX)) begin
            count_inc = count + COUNT_WIDTH'(1);
        end else begin
            count_inc = count;
        end
    end

    // Threshold compares on the updated count
    always_comb begin
        cnt       = CMP_W'(count_inc);
        thr_short = CMP_W'(cfg.short_ticks);
        thr_long  = CMP_W'(cfg.long_ticks);
        thr_rep   = CMP_W'(cfg.repeat_ticks);
        ge_short  = cnt >= thr_short;
        ge_long   = cnt >= thr_long;
        ge_rep    = cnt >= thr_rep;
    end

    // Rule group of this lane
    always_comb begin
        res = '0;
        if (KIND == KIND_NAV) begin
            if (!pressed && !lock && ge_short && !ge_long) begin
                res.hit  = 1'b1;
                res.emit = 1'b1;
            end else if (pressed && !lock && ge_long) begin
                res.hit      = 1'b1;
                res.emit     = 1'b1;
                res.lock_set = 1'b1;
            end else if (pressed && lock && ge_rep) begin
                res.hit  = 1'b1;
                res.emit = 1'b1;
            end else if (!pressed && lock) begin
                res.hit      = 1'b1;
                res.lock_clr = 1'b1;
            end
        end else begin
            // ok has no upper bound on a short release, cancel does
            if (!pressed && !lock && ge_short &&
                    ((KIND == KIND_OK) || !ge_long)) begin
                res.hit  = 1'b1;
                res.emit = 1'b1;
            end else if (pressed && !lock && ge_long) begin
                res.hit      = 1'b1;
                res.emit     = 1'b1;
                res.long_ev  = 1'b1;
                res.lock_set = 1'b1;
            end else if (!pressed && lock && !ge_short) begin
                res.hit      = 1'b1;
                res.lock_clr = 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/fbpc_merge.sv
module fbpc_merge
    import fbpc_pkg::*;
(
    input  lane_res_t lane_res [NUM_BUTTONS],
    output merge_t    merged
);

    // Fixed priority: up, down, ok, cancel; first hit decides the tick
    always_comb begin
        merged = '0;
        merged.ev = EV_WAIT;
        if (lane_res[BTN_UP].hit) begin
            merged.clear_all        = lane_res[BTN_UP].emit;
            merged.ev               = lane_res[BTN_UP].emit ? EV_UP : EV_WAIT;
            merged.lock_set[BTN_UP] = lane_res[BTN_UP].lock_set;
            merged.lock_clr[BTN_UP] = lane_res[BTN_UP].lock_clr;
        end else if (lane_res[BTN_DOWN].hit) begin
            merged.clear_all          = lane_res[BTN_DOWN].emit;
            merged.ev                 = lane_res[BTN_DOWN].emit ? EV_DOWN : EV_WAIT;
            merged.lock_set[BTN_DOWN] = lane_res[BTN_DOWN].lock_set;
            merged.lock_clr[BTN_DOWN] = lane_res[BTN_DOWN].lock_clr;
        end else if (lane_res[BTN_OK].hit) begin
            merged.clear_all        = lane_res[BTN_OK].emit;
            if (lane_res[BTN_OK].emit) begin
                merged.ev = lane_res[BTN_OK].long_ev ? EV_OK_LONG : EV_OK;
            end
            merged.lock_set[BTN_OK] = lane_res[BTN_OK].lock_set;
            merged.lock_clr[BTN_OK] = lane_res[BTN_OK].lock_clr;
        end else if (lane_res[BTN_CANCEL].hit) begin
            merged.clear_all            = lane_res[BTN_CANCEL].emit;
            if (lane_res[BTN_CANCEL].emit) begin
                merged.ev = lane_res[BTN_CANCEL].long_ev ? EV_BACK_LONG : EV_BACK;
            end
            merged.lock_set[BTN_CANCEL] = lane_res[BTN_CANCEL].lock_set;
            merged.lock_clr[BTN_CANCEL] = lane_res[BTN_CANCEL].lock_clr;
        end
    end

endmodule

// File: hw/rtl/four_button_press_classifier.sv
// Channel  | Ports          | Payload (lowest bit first)
// ---------+----------------+------------------------------------------------
// input    | s_t*           | up_level, down_level, ok_level, cancel_level
// result   | m_t*           | nav_event (3 bits)
// config   | cfg_we/addr/.. | short, long, repeat ticks, count_limit
//
// One scan tick per cycle: the four lanes and the priority merge settle the
// counter and lock update combinationally, and one result per tick lands in
// the output register. An input transfer is taken whenever the output
// register is empty or is being drained in the same cycle, so a stall on the
// result side holds the input side. Synchronous active-low reset clears the
// counters, locks and output valid and loads the register defaults.
module four_button_press_classifier
    import fbpc_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // up_level, down_level, ok_level, cancel_level
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // nav_event
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata
);

    cfg_t                   cfg_reg;
    logic [COUNT_WIDTH-1:0] count_reg [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] count_inc [NUM_BUTTONS];
    logic [COUNT_WIDTH-1:0] count_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] lock_reg;
    logic [NUM_BUTTONS-1:0] lock_next;
    logic [NUM_BUTTONS-1:0] pressed;
    lane_res_t              lane_res [NUM_BUTTONS];
    merge_t                 merged;
    logic                   m_tvalid_reg;
    logic [EV_W-1:0]        ev_reg;
    logic                   in_xfer;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(8 - EV_W){1'b0}}, ev_reg};

    // Active-low pins
    assign pressed = ~s_tdata[NUM_BUTTONS-1:0];

    // One lane per button
    for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
        localparam int unsigned LANE_KIND = (i == BTN_OK)     ? KIND_OK :
                                            (i == BTN_CANCEL) ? KIND_CANCEL :
                                                                KIND_NAV;
        fbpc_lane #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .KIND        (LANE_KIND)
        ) u_lane (
            .pressed   (pressed[i]),
            .lock      (lock_reg[i]),
            .count     (count_reg[i]),
            .cfg       (cfg_reg),
            .count_inc (count_inc[i]),
            .res       (lane_res[i])
        );
    end

    fbpc_merge u_merge (
        .lane_res (lane_res),
        .merged   (merged)
    );

    // Next counters and locks
    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            count_next[i] = merged.clear_all ? '0 : count_inc[i];
        end
        lock_next = (lock_reg | merged.lock_set) & ~merged.lock_clr;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_ticks  <= SHORT_TICKS_RST;
            cfg_reg.long_ticks   <= LONG_TICKS_RST;
            cfg_reg.repeat_ticks <= REPEAT_TICKS_RST;
            cfg_reg.count_limit  <= COUNT_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_SHORT_TICKS:  cfg_reg.short_ticks  <= cfg_wdata;
                REG_LONG_TICKS:   cfg_reg.long_ticks   <= cfg_wdata;
                REG_REPEAT_TICKS: cfg_reg.repeat_ticks <= cfg_wdata;
                REG_COUNT_LIMIT:  cfg_reg.count_limit  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Button state, updated on each input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                count_reg[i] <= '0;
            end
            lock_reg <= '0;
        end else if (in_xfer) begin
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                count_reg[i] <= count_next[i];
            end
            lock_reg <= lock_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (in_xfer) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            ev_reg <= merged.ev;
        end
    end

endmodule

// File: sim/tb_four_button_press_classifier.sv
module tb_four_button_press_classifier;
    import fbpc_pkg::*;

    localparam int unsigned CW              = COUNT_WIDTH_DEF;
    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned ITEMS_PER_PHASE = 110;
    localparam int unsigned HOLD_CAP        = 300;
    // Index past the last register; a write there must change nothing
    localparam logic [CFG_ADDR_W-1:0] REG_NONE = 3'd7;

    // Tracks hold counters, locks and thresholds; keeps the events still due
    class press_tracker;
        logic [CFG_W-1:0] short_t;
        logic [CFG_W-1:0] long_t;
        logic [CFG_W-1:0] repeat_t;
        logic [CFG_W-1:0] limit_t;
        logic [CW-1:0]    hold_cnt [NUM_BUTTONS];
        bit               locked   [NUM_BUTTONS];
        logic [EV_W-1:0]  due_events [$];
        int               errors;

        function new();
            short_t  = SHORT_TICKS_RST;
            long_t   = LONG_TICKS_RST;
            repeat_t = REPEAT_TICKS_RST;
            limit_t  = COUNT_LIMIT_RST;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                hold_cnt[b] = '0;
                locked[b]   = 1'b0;
            end
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_W-1:0] val);
            case (addr)
                REG_SHORT_TICKS:  short_t  = val;
                REG_LONG_TICKS:   long_t   = val;
                REG_REPEAT_TICKS: repeat_t = val;
                REG_COUNT_LIMIT:  limit_t  = val;
                default: ;
            endcase
        endfunction

        function void clear_counts();
            for (int b = 0; b < NUM_BUTTONS; b++)
                hold_cnt[b] = '0;
        endfunction

        // Priority chain: up, down, ok, cancel; first rule that holds decides
        function logic [EV_W-1:0] classify_tick(logic [NUM_BUTTONS-1:0] p);
            int              b;
            logic [EV_W-1:0] lane_ev;
            for (int i = 0; i < 2; i++) begin
                b       = (i == 0) ? BTN_UP : BTN_DOWN;
                lane_ev = (i == 0) ? EV_UP : EV_DOWN;
                if (!p[b] && !locked[b] && hold_cnt[b] >= short_t
                        && hold_cnt[b] < long_t) begin
                    clear_counts();
                    return lane_ev;
                end
                if (p[b] && !locked[b] && hold_cnt[b] >= long_t) begin
                    clear_counts();
                    locked[b] = 1'b1;
                    return lane_ev;
                end
                if (p[b] && locked[b] && hold_cnt[b] >= repeat_t) begin
                    clear_counts();
                    return lane_ev;
                end
                if (!p[b] && locked[b]) begin
                    locked[b] = 1'b0;
                    return EV_WAIT;
                end
            end
            // ok: short press has no upper bound
            if (!p[BTN_OK] && !locked[BTN_OK] && hold_cnt[BTN_OK] >= short_t) begin
                clear_counts();
                return EV_OK;
            end
            if (p[BTN_OK] && !locked[BTN_OK] && hold_cnt[BTN_OK] >= long_t) begin
                clear_counts();
                locked[BTN_OK] = 1'b1;
                return EV_OK_LONG;
            end
            if (!p[BTN_OK] && locked[BTN_OK] && hold_cnt[BTN_OK] < short_t) begin
                locked[BTN_OK] = 1'b0;
                return EV_WAIT;
            end
            // cancel
            if (!p[BTN_CANCEL] && !locked[BTN_CANCEL] && hold_cnt[BTN_CANCEL] >= short_t
                    && hold_cnt[BTN_CANCEL] < long_t) begin
                clear_counts();
                return EV_BACK;
            end
            if (p[BTN_CANCEL] && !locked[BTN_CANCEL] && hold_cnt[BTN_CANCEL] >= long_t) begin
                clear_counts();
                locked[BTN_CANCEL] = 1'b1;
                return EV_BACK_LONG;
            end
            if (!p[BTN_CANCEL] && locked[BTN_CANCEL] && hold_cnt[BTN_CANCEL] < short_t)
                locked[BTN_CANCEL] = 1'b0;
            return EV_WAIT;
        endfunction

        // One accepted scan tick: count, then classify
        function void take_tick(logic [NUM_BUTTONS-1:0] lv);
            logic [NUM_BUTTONS-1:0] p;
            bit                     en;
            p = ~lv;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                en = p[b] && (b == BTN_UP || b == BTN_DOWN || !locked[b]);
                // saturates at limit + 1 and never wraps past the top value
                if (en && hold_cnt[b] <= limit_t && hold_cnt[b] != '1)
                    hold_cnt[b] = hold_cnt[b] + 1'b1;
            end
            due_events.push_back(classify_tick(p));
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task match_event(logic [7:0] data);
            logic [EV_W-1:0] want;
            if (due_events.size() == 0) begin
                report($sformatf("event %0d with nothing due", data));
                return;
            end
            want = due_events.pop_front();
            if (data !== {{(8 - EV_W){1'b0}}, want})
                report($sformatf("nav_event got %0d, want %0d", data, want));
        endtask
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;

    press_tracker board;
    int unsigned  cyc = 0;
    int unsigned  phase_items;
    int unsigned  burst_left;
    bit           gaps_on;

    four_button_press_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: check each transfer, stall on a rotating pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.match_event(m_tdata);
        case ((cyc / 300) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 6);
            2: m_tready <= ((cyc % 7) < 3);
            default: m_tready <= ((cyc % 13) == 0);
        endcase
    end

    // One input transfer, preceded by a gap when a burst runs out and gaps are on
    task automatic send_tick(input logic [NUM_BUTTONS-1:0] lv);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(8, 1) : 0;
            repeat (gap) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
            burst_left = $urandom_range(24, 1);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(8 - NUM_BUTTONS){1'b0}}, lv};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.take_tick(lv);
        phase_items++;
    endtask

    // Hold the masked buttons, then release all; optional stray flips
    task automatic press_run(input logic [NUM_BUTTONS-1:0] mask, input int unsigned hold,
                             input int unsigned rel, input bit noisy);
        logic [NUM_BUTTONS-1:0] lv;
        int unsigned            idx;
        for (int unsigned i = 0; i < hold + rel; i++) begin
            lv = (i < hold) ? ~mask : '1;
            if (noisy && $urandom_range(15, 0) == 0) begin
                idx     = $urandom_range(NUM_BUTTONS - 1, 0);
                lv[idx] = ~lv[idx];
            end
            send_tick(lv);
        end
    endtask

    // Hold lengths aimed around the thresholds in force
    function automatic int unsigned pick_hold(input cfg_t c);
        int unsigned s = c.short_ticks;
        int unsigned l = c.long_ticks;
        int unsigned r = c.repeat_ticks;
        int unsigned lo, hi, t;
        case ($urandom_range(4, 0))
            0: begin lo = 1; hi = s + 1; end
            1: begin lo = s; hi = l; end
            2: begin lo = (l > 0) ? l - 1 : 0; hi = l + 1; end
            3: begin lo = l; hi = l + 3 * r + 2; end
            default: begin lo = 0; hi = 40; end
        endcase
        if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        if (hi > HOLD_CAP) hi = HOLD_CAP;
        if (lo > hi) lo = hi;
        return $urandom_range(hi, lo);
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        board.set_reg(addr, val);
    endtask

    // Registers change only with nothing in flight
    task automatic load_config(input cfg_t c, input bit poke_none);
        s_tvalid <= 1'b0;
        while (board.due_events.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
        write_reg(REG_SHORT_TICKS, c.short_ticks);
        write_reg(REG_LONG_TICKS, c.long_ticks);
        write_reg(REG_REPEAT_TICKS, c.repeat_ticks);
        write_reg(REG_COUNT_LIMIT, c.count_limit);
        if (poke_none)
            write_reg(REG_NONE, CFG_W'($urandom_range(255, 0)));
        cfg_we <= 1'b0;
    endtask

    // Mostly clean press sequences, some chords and random level noise
    task automatic run_random(input cfg_t c);
        int unsigned sel;
        phase_items = 0;
        gaps_on     = ($urandom_range(3, 0) != 0);
        while (phase_items < ITEMS_PER_PHASE) begin
            sel = $urandom_range(9, 0);
            if (sel < 6)
                press_run(4'b0001 << $urandom_range(3, 0), pick_hold(c),
                          $urandom_range(3, 1), sel == 5);
            else if (sel < 8)
                press_run(NUM_BUTTONS'($urandom_range(15, 1)), pick_hold(c),
                          $urandom_range(3, 1), 1'b1);
            else
                repeat ($urandom_range(6, 1)) send_tick(NUM_BUTTONS'($urandom_range(15, 0)));
        end
    endtask

    initial begin
        cfg_t c;
        board      = new();
        burst_left = 0;
        gaps_on    = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h0f;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: each event kind, lock and unlock with tiny thresholds
        c = '{short_ticks: 8'd1, long_ticks: 8'd4, repeat_ticks: 8'd2, count_limit: 8'd254};
        load_config(c, 1'b0);
        press_run(4'b0000, 0, 1, 1'b0);
        press_run(4'b0001 << BTN_UP, 5, 1, 1'b0);
        press_run(4'b0001 << BTN_DOWN, 2, 1, 1'b0);
        press_run(4'b0001 << BTN_OK, 2, 1, 1'b0);
        press_run(4'b0001 << BTN_OK, 5, 1, 1'b0);
        press_run(4'b0001 << BTN_CANCEL, 2, 1, 1'b0);
        press_run(4'b0001 << BTN_CANCEL, 4, 1, 1'b0);
        press_run(4'b1111, 1, 1, 1'b0);

        // Random phases over several threshold settings
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: c = '{SHORT_TICKS_RST, LONG_TICKS_RST, REPEAT_TICKS_RST, COUNT_LIMIT_RST};
                1: c = '{8'd0, 8'd0, 8'd0, 8'd0};
                2: c = '{8'd255, 8'd255, 8'd255, 8'd255};
                3: c = '{8'd2, 8'd8, 8'd3, 8'd5};      // limit caps counts below long
                4: c = '{8'd6, 8'd3, 8'd1, 8'd254};    // crossed thresholds
                5: c = '{8'd0, 8'd255, 8'd0, 8'd254};
                default: begin
                    c.short_ticks  = CFG_W'($urandom_range(6, 0));
                    c.long_ticks   = CFG_W'($urandom_range(16, 0));
                    c.repeat_ticks = CFG_W'($urandom_range(6, 0));
                    c.count_limit  = ($urandom_range(3, 0) == 0) ?
                                     CFG_W'($urandom_range(255, 0)) : 8'd254;
                end
            endcase
            load_config(c, (ph % 3) == 1);
            run_random(c);
        end

        // Drain and finish
        s_tvalid <= 1'b0;
        while (board.due_events.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: four_button_press_classifier.f
hw/rtl/fbpc_pkg.sv
hw/rtl/fbpc_lane.sv
hw/rtl/fbpc_merge.sv
hw/rtl/four_button_press_classifier.sv
sim/tb_four_button_press_classifier.sv
